FILE: src/dxsort_pkg.sv
// shared types and constants for the descending exchange sort block
// no dependencies; imported by the top level and its checker
package dxsort_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int KEY_BITS    = 32;
  localparam int ID_BITS     = 16;
  localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
  localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [ID_BITS-1:0]  id_t;
  typedef logic [IDX_BITS-1:0] idx_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_I,
    ST_LD_I,
    ST_SCAN,
    ST_EMIT
  } state_e;

endpackage

FILE: src/descending_exchange_sort_indices.sv
// top level of the descending exchange sort of entry ids by key
// depends on dxsort_pkg; key and id stores are memories with a registered read inside
//
// usage:
//   input channel (in_valid_i / in_ready_o) takes one item per cycle while the
//   block is loading: entry_id_i, sort_key_i and last_item_i. items beyond
//   MAX_ENTRIES are dropped and flagged on the final result.
//   an item with last_item_i set ends the list; in_ready_o then drops until
//   the whole sorted list has been delivered.
//   output channel (out_valid_o / out_ready_i) gives the ids largest key first,
//   last_result_o on the final id, overflowed_o on the final id if any item
//   was dropped. equal keys keep the order of the exchange passes.
//   operation: after loading, each output position i of n gets a pass
//   (read of position i, then one compare per cycle on the single memory
//   read port against positions i+1 to n-1) and then the result handover.
//   a stalled receiver simply holds the block in the result handover, with
//   the result steady. reset returns to loading with an empty list; the
//   memories are not cleared since only entries of the current list are read.
module descending_exchange_sort_indices (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dxsort_pkg::id_t   entry_id_i,
  input  dxsort_pkg::key_t  sort_key_i,
  input  logic              last_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dxsort_pkg::id_t   sorted_id_o,
  output logic              last_result_o,
  output logic              overflowed_o
);
  import dxsort_pkg::*;

  key_t key_mem [MAX_ENTRIES];
  id_t  id_mem  [MAX_ENTRIES];

  state_e state_q, state_d;
  cnt_t   count_q, count_d;
  logic   drop_q, drop_d;
  idx_t   i_q, i_d;
  idx_t   j_q, j_d;
  key_t   held_key_q, held_key_d;
  id_t    held_id_q, held_id_d;

  logic   rd_en;
  idx_t   rd_addr;
  key_t   rd_key_q;
  id_t    rd_id_q;
  logic   wr_en;
  idx_t   wr_addr;
  key_t   wr_key;
  id_t    wr_id;

  logic   in_acc;
  cnt_t   i_nxt;
  cnt_t   j_nxt;
  logic   fin;

  assign in_acc = in_valid_i && in_ready_o;
  assign i_nxt  = cnt_t'(i_q) + cnt_t'(1);
  assign j_nxt  = cnt_t'(j_q) + cnt_t'(1);
  assign fin    = (i_nxt == count_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      id_mem[wr_addr]  <= wr_id;
    end
    if (rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_id_q  <= id_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_key_q <= held_key_d;
    held_id_q  <= held_id_d;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    drop_d     = drop_q;
    i_d        = i_q;
    j_d        = j_q;
    held_key_d = held_key_q;
    held_id_d  = held_id_q;
    rd_en      = 1'b0;
    rd_addr    = i_q;
    wr_en      = 1'b0;
    wr_addr    = j_q;
    wr_key     = held_key_q;
    wr_id      = held_id_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        wr_addr    = count_q[IDX_BITS-1:0];
        wr_key     = sort_key_i;
        wr_id      = entry_id_i;
        if (in_acc) begin
          if (count_q < cnt_t'(MAX_ENTRIES)) begin
            wr_en   = 1'b1;
            count_d = count_q + cnt_t'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (last_item_i) begin
            i_d     = '0;
            state_d = ST_RD_I;
          end
        end
      end
      ST_RD_I: begin
        rd_en   = 1'b1;
        rd_addr = i_q;
        state_d = ST_LD_I;
      end
      ST_LD_I: begin
        held_key_d = rd_key_q;
        held_id_d  = rd_id_q;
        if (i_nxt < count_q) begin
          rd_en   = 1'b1;
          rd_addr = i_nxt[IDX_BITS-1:0];
          j_d     = i_nxt[IDX_BITS-1:0];
          state_d = ST_SCAN;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SCAN: begin
        // strictly greater key moves into position i, old holder goes to j
        if (rd_key_q > held_key_q) begin
          wr_en      = 1'b1;
          held_key_d = rd_key_q;
          held_id_d  = rd_id_q;
        end
        if (j_nxt < count_q) begin
          rd_en   = 1'b1;
          rd_addr = j_nxt[IDX_BITS-1:0];
          j_d     = j_nxt[IDX_BITS-1:0];
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (fin) begin
            count_d = '0;
            drop_d  = 1'b0;
            state_d = ST_LOAD;
          end else begin
            i_d     = i_nxt[IDX_BITS-1:0];
            state_d = ST_RD_I;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign sorted_id_o   = held_id_q;
  assign last_result_o = fin;
  assign overflowed_o  = fin && drop_q;

endmodule

FILE: src/dxsort_checker.sv
// port-level checks for descending_exchange_sort_indices
// depends on dxsort_pkg; bound to the top level at the end of this file
module dxsort_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            last_item_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input dxsort_pkg::id_t sorted_id_o,
  input logic            last_result_o,
  input logic            overflowed_o
);
  import dxsort_pkg::*;

  // loading and result handover never overlap
  a_load_xor_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is offered");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sorted_id_o)
      && $stable(last_result_o) && $stable(overflowed_o))
    else $error("result changed while stalled");

  // overflow is only reported on the final id
  a_ovf_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflowed_o |-> last_result_o)
    else $error("overflow flag before the final id");

  // the item that ends a list closes the input right after it is taken
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_item_i |=> !in_ready_o)
    else $error("input still open after the final item");

  // delivering the final id reopens the input
  a_done_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_result_o |=> in_ready_o && !out_valid_o)
    else $error("block not back to loading after the final id");

endmodule

bind descending_exchange_sort_indices dxsort_checker u_dxsort_checker (.*);
